[rtl/drblm_pkg.sv]
// Shared constants and types for the DRAM row buffer latency model.
package drblm_pkg;

	localparam int ADDR_W     = 48;
	localparam int BANK_COUNT = 16;
	localparam int BANK_W     = $clog2(BANK_COUNT);
	localparam int ROW_W      = ADDR_W - BANK_W;
	localparam int SHIFT_W    = 4;
	localparam int LAT_W      = 8;
	localparam int OUTC_W     = 3;
	localparam int CNT_W      = 48;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 4;

	localparam logic [LAT_W-1:0] LAT_ACT   = 8'd45;
	localparam logic [LAT_W-1:0] LAT_CAS   = 8'd45;
	localparam logic [LAT_W-1:0] LAT_PRE   = 8'd45;
	localparam logic [LAT_W-1:0] LAT_BUS   = 8'd10;
	localparam logic [LAT_W-1:0] LAT_FIXED = 8'd100;

	localparam logic [LAT_W-1:0] LAT_HIT      = LAT_CAS + LAT_BUS;
	localparam logic [LAT_W-1:0] LAT_EMPTY    = LAT_ACT + LAT_CAS + LAT_BUS;
	localparam logic [LAT_W-1:0] LAT_CONFLICT = LAT_PRE + LAT_ACT + LAT_CAS + LAT_BUS;

	localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

	localparam logic [SHIFT_W-1:0] SHIFT_RESET = 4'd4;

	localparam logic [CFG_IDX_W-1:0] CFG_FIXED_MODE  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_CLOSE_PAGE  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_ROW_SHIFT   = 2'd2;

	typedef enum logic [OUTC_W-1:0] {
		OUTC_FIXED    = 3'd0,
		OUTC_CLOSED   = 3'd1,
		OUTC_HIT      = 3'd2,
		OUTC_EMPTY    = 3'd3,
		OUTC_CONFLICT = 3'd4
	} outcome_t;

	// Result of a bank lookup.
	typedef struct packed {
		logic open;
		logic row_match;
	} bank_status_t;

	// One finished transaction handed to the statistics counters.
	typedef struct packed {
		logic             fire;
		logic             is_write;
		logic [LAT_W-1:0] latency;
	} stat_update_t;

endpackage

[rtl/drblm_bank_table.sv]
// Per-bank open row table with lookup and update.
module drblm_bank_table (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic [drblm_pkg::BANK_W-1:0]   bank,
	input  logic [drblm_pkg::ROW_W-1:0]    row,
	input  logic                           update,
	output drblm_pkg::bank_status_t        status
);
	import drblm_pkg::*;

	logic [BANK_COUNT-1:0] open_q;
	logic [ROW_W-1:0]      row_id_q [BANK_COUNT];

	always_comb begin
		status.open      = open_q[bank];
		status.row_match = (row_id_q[bank] == row);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			open_q <= '0;
		end else if (update) begin
			open_q[bank] <= 1'b1;
		end
	end

	// Row ids are only looked at once their bank is open.
	always_ff @(posedge clk) begin
		if (update) begin
			row_id_q[bank] <= row;
		end
	end

endmodule

[rtl/drblm_stats.sv]
// Saturating per-type access counters and latency sums.
module drblm_stats (
	input  logic                         clk,
	input  logic                         arst_n,
	input  drblm_pkg::stat_update_t      upd,
	output logic [drblm_pkg::CNT_W-1:0]  read_accesses,
	output logic [drblm_pkg::CNT_W-1:0]  write_accesses,
	output logic [drblm_pkg::CNT_W-1:0]  read_delay_total,
	output logic [drblm_pkg::CNT_W-1:0]  write_delay_total
);
	import drblm_pkg::*;

	logic [CNT_W-1:0] rd_cnt_q, wr_cnt_q, rd_sum_q, wr_sum_q;
	logic [CNT_W-1:0] cnt_sel, sum_sel, cnt_next, sum_next;
	logic [CNT_W:0]   sum_wide;

	always_comb begin
		cnt_sel  = upd.is_write ? wr_cnt_q : rd_cnt_q;
		sum_sel  = upd.is_write ? wr_sum_q : rd_sum_q;
		cnt_next = (cnt_sel == CNT_MAX) ? CNT_MAX : cnt_sel + CNT_W'(1);
		sum_wide = {1'b0, sum_sel} + {{(CNT_W + 1 - LAT_W){1'b0}}, upd.latency};
		sum_next = sum_wide[CNT_W] ? CNT_MAX : sum_wide[CNT_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_cnt_q <= '0;
			wr_cnt_q <= '0;
			rd_sum_q <= '0;
			wr_sum_q <= '0;
		end else if (upd.fire) begin
			if (upd.is_write) begin
				wr_cnt_q <= cnt_next;
				wr_sum_q <= sum_next;
			end else begin
				rd_cnt_q <= cnt_next;
				rd_sum_q <= sum_next;
			end
		end
	end

	assign read_accesses     = rd_cnt_q;
	assign write_accesses    = wr_cnt_q;
	assign read_delay_total  = rd_sum_q;
	assign write_delay_total = wr_sum_q;

endmodule

[rtl/dram_row_buffer_latency_model_top.sv]
// Top level of the DRAM row buffer latency model.
// An accepted transaction waits in stage one until the result register is free or drained.
// Throughput: one transaction per cycle while the result side does not stall, set by
// the single bank table lookup and update. Reset (arst_n low) empties all banks, zeroes
// the counters and restores the register defaults: fixed mode off, open page, and a
// row shift of four, the log2 of sixteen lines per row.
module dram_row_buffer_latency_model_top (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic [drblm_pkg::ADDR_W-1:0]        line_address,
	input  logic                                is_write,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic [drblm_pkg::LAT_W-1:0]         latency,
	output logic [drblm_pkg::OUTC_W-1:0]        outcome,
	output logic [drblm_pkg::CNT_W-1:0]         read_accesses,
	output logic [drblm_pkg::CNT_W-1:0]         write_accesses,
	output logic [drblm_pkg::CNT_W-1:0]         read_delay_total,
	output logic [drblm_pkg::CNT_W-1:0]         write_delay_total,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [drblm_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [drblm_pkg::CFG_DATA_W-1:0]    cfg_data
);
	import drblm_pkg::*;

	// Configuration registers. Writes are always taken; an index past the
	// last register is dropped.
	logic               fixed_mode_q;
	logic               close_page_q;
	logic [SHIFT_W-1:0] row_shift_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fixed_mode_q <= 1'b0;
			close_page_q <= 1'b0;
			row_shift_q  <= SHIFT_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_FIXED_MODE: fixed_mode_q <= cfg_data[0];
				CFG_CLOSE_PAGE: close_page_q <= cfg_data[0];
				CFG_ROW_SHIFT:  row_shift_q  <= cfg_data[SHIFT_W-1:0];
				default:        ;
			endcase
		end
	end

	// Stage one holds the accepted transaction. It moves on into the result
	// register whenever that register is empty or being drained this cycle,
	// and only at that edge are the bank table and counters updated, so each
	// transaction sees the state left by the one before it.
	logic              valid_s1;
	logic [ADDR_W-1:0] addr_s1;
	logic              write_s1;
	logic              advance;

	assign advance  = valid_s1 && (!out_valid || !out_stall);
	assign in_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			addr_s1  <= line_address;
			write_s1 <= is_write;
		end
	end

	// Split the address into bank and row: the low bits of the row chunk
	// pick the bank and the rest is the row id.
	logic [ADDR_W-1:0] chunk;
	logic [BANK_W-1:0] bank;
	logic [ROW_W-1:0]  row;
	bank_status_t      bank_status;

	assign chunk = addr_s1 >> row_shift_q;
	assign bank  = chunk[BANK_W-1:0];
	assign row   = chunk[ADDR_W-1:BANK_W];

	drblm_bank_table u_bank_table (
		.clk    (clk),
		.arst_n (arst_n),
		.bank   (bank),
		.row    (row),
		.update (advance && !fixed_mode_q),
		.status (bank_status)
	);

	// Pick the latency class. Fixed mode leaves the banks alone; both page
	// policies record the row as open afterwards.
	logic [LAT_W-1:0] lat_calc;
	outcome_t         outc_calc;

	always_comb begin
		if (fixed_mode_q) begin
			lat_calc  = LAT_FIXED;
			outc_calc = OUTC_FIXED;
		end else if (close_page_q) begin
			lat_calc  = LAT_EMPTY;
			outc_calc = OUTC_CLOSED;
		end else if (bank_status.open && bank_status.row_match) begin
			lat_calc  = LAT_HIT;
			outc_calc = OUTC_HIT;
		end else if (bank_status.open) begin
			lat_calc  = LAT_CONFLICT;
			outc_calc = OUTC_CONFLICT;
		end else begin
			lat_calc  = LAT_EMPTY;
			outc_calc = OUTC_EMPTY;
		end
	end

	// The counters change only when a transaction enters the result
	// register, so they hold steady while that result waits.
	stat_update_t stat_upd;

	assign stat_upd.fire     = advance;
	assign stat_upd.is_write = write_s1;
	assign stat_upd.latency  = lat_calc;

	drblm_stats u_stats (
		.clk               (clk),
		.arst_n            (arst_n),
		.upd               (stat_upd),
		.read_accesses     (read_accesses),
		.write_accesses    (write_accesses),
		.read_delay_total  (read_delay_total),
		.write_delay_total (write_delay_total)
	);

	// Result register.
	logic             out_valid_q;
	logic [LAT_W-1:0] lat_q;
	outcome_t         outc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			lat_q  <= lat_calc;
			outc_q <= outc_calc;
		end
	end

	assign out_valid = out_valid_q;
	assign latency   = lat_q;
	assign outcome   = outc_q;

endmodule

[verif/testbench.sv]
// Self-checking testbench for the DRAM row buffer latency model top level.
module testbench;
	import drblm_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	// The fourth register index is not mapped in the block, so a write to it must be dropped.
	localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED = 2'd3;

	localparam int CYCLE_LIMIT    = 400000;
	localparam int HOLD_CYCLES    = 300;
	localparam int SETTLE_CYCLES  = 8;
	localparam int SEGMENT_COUNT  = 6;
	localparam int SEGMENT_ITEMS  = 192;
	localparam int DIRECTED_STEPS = 25;

	typedef enum logic [0:0] {
		STEP_ACCESS,
		STEP_CONFIG
	} step_kind_t;

	// One row of the directed plan: either a register write or a memory access.
	// Where known_timing is set, the latency and outcome are the literal expected values.
	typedef struct packed {
		step_kind_t            kind;
		logic [CFG_IDX_W-1:0]  index;
		logic [CFG_DATA_W-1:0] data;
		logic [ADDR_W-1:0]     addr;
		logic                  wr;
		logic                  known_timing;
		logic [LAT_W-1:0]      lat;
		outcome_t              outc;
	} directed_step_t;

	// Everything the block reports for one access.
	typedef struct packed {
		logic [LAT_W-1:0] latency;
		outcome_t         outcome;
		logic [CNT_W-1:0] reads;
		logic [CNT_W-1:0] writes;
		logic [CNT_W-1:0] read_delay;
		logic [CNT_W-1:0] write_delay;
	} access_timing_t;

	localparam logic [ADDR_W-1:0] ADDR_TOP = {ADDR_W{1'b1}};

	// The directed plan starts from the reset settings: open page, sixteen lines per row.
	// Bank 0 goes empty, hit and conflict; the top address opens bank 15 with the widest row.
	// Fixed mode must leave the banks alone, and close page must still record the row it opened.
	// Then the shift goes to zero and to fifteen, an unmapped register write is dropped, and
	// the shift is set to ten before it returns to the reset value.
	directed_step_t directed_plan [DIRECTED_STEPS] = '{
		'{STEP_ACCESS, CFG_FIXED_MODE, 4'd0, 48'h0,    1'b0, 1'b1, 8'd100, OUTC_EMPTY},
		'{STEP_ACCESS, CFG_FIXED_MODE, 4'd0, 48'h5,    1'b0, 1'b1, 8'd55,  OUTC_HIT},
		'{STEP_ACCESS, CFG_FIXED_MODE, 4'd0, 48'h100,  1'b1, 1'b1, 8'd145, OUTC_CONFLICT},
		'{STEP_ACCESS, CFG_FIXED_MODE, 4'd0, 48'h10,   1'b1, 1'b1, 8'd100, OUTC_EMPTY},
		'{STEP_ACCESS, CFG_FIXED_MODE, 4'd0, ADDR_TOP, 1'b0, 1'b1, 8'd100, OUTC_EMPTY},
		'{STEP_ACCESS, CFG_FIXED_MODE, 4'd0, ADDR_TOP, 1'b1, 1'b1, 8'd55,  OUTC_HIT},
		'{STEP_CONFIG, CFG_FIXED_MODE, 4'd1, 48'h0,    1'b0, 1'b0, 8'd0,   OUTC_FIXED},
		'{STEP_ACCESS, CFG_FIXED_MODE, 4'd0, 48'h100,  1'b0, 1'b1, 8'd100, OUTC_FIXED},
		'{STEP_ACCESS, CFG_FIXED_MODE, 4'd0, 48'h200,  1'b1, 1'b1, 8'd100, OUTC_FIXED},
		'{STEP_CONFIG, CFG_FIXED_MODE, 4'd0, 48'h0,    1'b0, 1'b0, 8'd0,   OUTC_FIXED},
		'{STEP_ACCESS, CFG_FIXED_MODE, 4'd0, 48'h100,  1'b0, 1'b1, 8'd55,  OUTC_HIT},
		'{STEP_CONFIG, CFG_CLOSE_PAGE, 4'd1, 48'h0,    1'b0, 1'b0, 8'd0,   OUTC_FIXED},
		'{STEP_ACCESS, CFG_FIXED_MODE, 4'd0, 48'h300,  1'b0, 1'b1, 8'd100, OUTC_CLOSED},
		'{STEP_ACCESS, CFG_FIXED_MODE, 4'd0, 48'h100,  1'b1, 1'b1, 8'd100, OUTC_CLOSED},
		'{STEP_CONFIG, CFG_CLOSE_PAGE, 4'd0, 48'h0,    1'b0, 1'b0, 8'd0,   OUTC_FIXED},
		'{STEP_ACCESS, CFG_FIXED_MODE, 4'd0, 48'h100,  1'b0, 1'b1, 8'd55,  OUTC_HIT},
		'{STEP_CONFIG, CFG_ROW_SHIFT,  4'd0, 48'h0,    1'b0, 1'b0, 8'd0,   OUTC_FIXED},
		'{STEP_ACCESS, CFG_FIXED_MODE, 4'd0, 48'h0,    1'b0, 1'b1, 8'd145, OUTC_CONFLICT},
		'{STEP_CONFIG, CFG_ROW_SHIFT,  4'd15, 48'h0,   1'b0, 1'b0, 8'd0,   OUTC_FIXED},
		'{STEP_ACCESS, CFG_FIXED_MODE, 4'd0, 48'h8000, 1'b1, 1'b1, 8'd55,  OUTC_HIT},
		'{STEP_CONFIG, CFG_UNMAPPED,   4'd15, 48'h0,   1'b0, 1'b0, 8'd0,   OUTC_FIXED},
		'{STEP_ACCESS, CFG_FIXED_MODE, 4'd0, ADDR_TOP, 1'b0, 1'b1, 8'd145, OUTC_CONFLICT},
		'{STEP_CONFIG, CFG_ROW_SHIFT,  4'd10, 48'h0,   1'b0, 1'b0, 8'd0,   OUTC_FIXED},
		'{STEP_ACCESS, CFG_FIXED_MODE, 4'd0, 48'h2AAA55551234, 1'b1, 1'b0, 8'd0, OUTC_FIXED},
		'{STEP_CONFIG, CFG_ROW_SHIFT,  4'd4, 48'h0,    1'b0, 1'b0, 8'd0,   OUTC_FIXED}
	};

	// Every input of the block starts at a known value.
	logic                  clk          = 1'b0;
	logic                  arst_n       = 1'b0;
	logic                  in_valid     = 1'b0;
	logic [ADDR_W-1:0]     line_address = '0;
	logic                  is_write     = 1'b0;
	logic                  out_stall    = 1'b0;
	logic                  cfg_valid    = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index    = CFG_FIXED_MODE;
	logic [CFG_DATA_W-1:0] cfg_data     = '0;

	logic                  in_stall;
	logic                  out_valid;
	logic [LAT_W-1:0]      latency;
	logic [OUTC_W-1:0]     outcome;
	logic [CNT_W-1:0]      read_accesses;
	logic [CNT_W-1:0]      write_accesses;
	logic [CNT_W-1:0]      read_delay_total;
	logic [CNT_W-1:0]      write_delay_total;
	logic                  cfg_ready;

	// Literal expectations travel alongside the transaction they belong to and are held
	// stable with it while the block stalls.
	logic                  step_known = 1'b0;
	logic [LAT_W-1:0]      step_lat   = '0;
	outcome_t              step_outc  = OUTC_FIXED;

	// Predicted copy of the block's registers and bank table.
	logic                  cfg_fixed     = 1'b0;
	logic                  cfg_close     = 1'b0;
	logic [SHIFT_W-1:0]    cfg_row_shift = SHIFT_RESET;
	logic                  bank_open [BANK_COUNT];
	logic [ROW_W-1:0]      bank_row  [BANK_COUNT];
	logic [CNT_W-1:0]      read_total_count  = '0;
	logic [CNT_W-1:0]      write_total_count = '0;
	logic [CNT_W-1:0]      read_total_delay  = '0;
	logic [CNT_W-1:0]      write_total_delay = '0;

	access_timing_t        pending_timings [$];

	int unsigned           send_idle_pct = 0;
	int unsigned           recv_idle_pct = 0;
	logic                  hold_request  = 1'b0;
	logic                  hold_served   = 1'b0;
	int unsigned           mismatch_count = 0;
	int unsigned           cycle_count    = 0;

	dram_row_buffer_latency_model_top u_top (
		.clk               (clk),
		.arst_n            (arst_n),
		.in_valid          (in_valid),
		.in_stall          (in_stall),
		.line_address      (line_address),
		.is_write          (is_write),
		.out_valid         (out_valid),
		.out_stall         (out_stall),
		.latency           (latency),
		.outcome           (outcome),
		.read_accesses     (read_accesses),
		.write_accesses    (write_accesses),
		.read_delay_total  (read_delay_total),
		.write_delay_total (write_delay_total),
		.cfg_valid         (cfg_valid),
		.cfg_ready         (cfg_ready),
		.cfg_index         (cfg_index),
		.cfg_data          (cfg_data)
	);

	always #1 clk = ~clk;

	initial begin
		for (int b = 0; b < BANK_COUNT; b++) begin
			bank_open[b] = 1'b0;
			bank_row[b]  = '0;
		end
	end

	task automatic report_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] want);
		$display("%0t mismatch in %s: got %0h, expected %0h", $realtime, what, got, want);
		mismatch_count++;
	endtask

	// Counters and delay sums stick at their maximum instead of wrapping.
	function automatic logic [CNT_W-1:0] sat_accumulate(input logic [CNT_W-1:0] acc,
			input logic [LAT_W-1:0] inc);
		logic [CNT_W:0] sum;
		sum = {1'b0, acc} + (CNT_W + 1)'(inc);
		return sum[CNT_W] ? CNT_MAX : sum[CNT_W-1:0];
	endfunction

	// Works out the timing of one access and advances the bank table and the statistics.
	function automatic access_timing_t predict_access_timing(input logic [ADDR_W-1:0] addr,
			input logic wr);
		access_timing_t    r;
		logic [ADDR_W-1:0] chunk;
		logic [BANK_W-1:0] bank;
		logic [ROW_W-1:0]  row;
		chunk = addr >> cfg_row_shift;
		bank  = chunk[BANK_W-1:0];
		row   = chunk[ADDR_W-1:BANK_W];
		if (cfg_fixed) begin
			r.latency = LAT_FIXED;
			r.outcome = OUTC_FIXED;
		end else begin
			if (cfg_close) begin
				r.latency = LAT_ACT + LAT_CAS + LAT_BUS;
				r.outcome = OUTC_CLOSED;
			end else if (bank_open[bank] && bank_row[bank] == row) begin
				r.latency = LAT_CAS + LAT_BUS;
				r.outcome = OUTC_HIT;
			end else if (bank_open[bank]) begin
				r.latency = LAT_PRE + LAT_ACT + LAT_CAS + LAT_BUS;
				r.outcome = OUTC_CONFLICT;
			end else begin
				r.latency = LAT_ACT + LAT_CAS + LAT_BUS;
				r.outcome = OUTC_EMPTY;
			end
			bank_open[bank] = 1'b1;
			bank_row[bank]  = row;
		end
		if (wr) begin
			write_total_count = sat_accumulate(write_total_count, LAT_W'(1));
			write_total_delay = sat_accumulate(write_total_delay, r.latency);
		end else begin
			read_total_count = sat_accumulate(read_total_count, LAT_W'(1));
			read_total_delay = sat_accumulate(read_total_delay, r.latency);
		end
		r.reads       = read_total_count;
		r.writes      = write_total_count;
		r.read_delay  = read_total_delay;
		r.write_delay = write_total_delay;
		return r;
	endfunction

	// Mostly addresses built from a few rows and banks at the current row size, so that
	// hits, conflicts and empty banks all come up often; the rest is raw noise.
	function automatic logic [ADDR_W-1:0] pick_line_address(input logic [SHIFT_W-1:0] sh);
		logic [63:0]       noise;
		logic [ADDR_W-1:0] row_part;
		logic [ADDR_W-1:0] bank_part;
		logic [ADDR_W-1:0] offset;
		noise = {$urandom, $urandom};
		if ($urandom_range(99) < 15) begin
			return noise[ADDR_W-1:0];
		end
		row_part  = ($urandom_range(7) == 0) ? ADDR_W'({$urandom, $urandom})
			: ADDR_W'($urandom_range(3));
		bank_part = ADDR_W'($urandom_range(BANK_COUNT - 1));
		offset    = noise[ADDR_W-1:0] & ((ADDR_W'(1) << sh) - 1);
		return (row_part << (sh + BANK_W)) | (bank_part << sh) | offset;
	endfunction

	// All sampling happens here, at the rising edge, on values from before the edge.
	// The result side is checked before the request side, which is safe because a result
	// never leaves in the same cycle as its own transaction is taken.
	always @(posedge clk) begin : scoreboard
		access_timing_t want;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (pending_timings.size() == 0) begin
					report_mismatch("result with nothing outstanding", 64'(latency), 64'd0);
				end else begin
					want = pending_timings.pop_front();
					if (latency !== want.latency)
						report_mismatch("latency", 64'(latency), 64'(want.latency));
					if (outcome !== want.outcome)
						report_mismatch("outcome", 64'(outcome), 64'(want.outcome));
					if (read_accesses !== want.reads)
						report_mismatch("read_accesses", 64'(read_accesses), 64'(want.reads));
					if (write_accesses !== want.writes)
						report_mismatch("write_accesses", 64'(write_accesses),
							64'(want.writes));
					if (read_delay_total !== want.read_delay)
						report_mismatch("read_delay_total", 64'(read_delay_total),
							64'(want.read_delay));
					if (write_delay_total !== want.write_delay)
						report_mismatch("write_delay_total", 64'(write_delay_total),
							64'(want.write_delay));
				end
			end
			// A write to an unmapped index leaves every register unchanged.
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_FIXED_MODE: cfg_fixed     = cfg_data[0];
					CFG_CLOSE_PAGE: cfg_close     = cfg_data[0];
					CFG_ROW_SHIFT:  cfg_row_shift = cfg_data;
					default: ;
				endcase
			end
			if (in_valid && !in_stall) begin
				want = predict_access_timing(line_address, is_write);
				if (step_known) begin
					want.latency = step_lat;
					want.outcome = step_outc;
				end
				pending_timings.push_back(want);
			end
		end
	end

	// The result side stalls at random, except for one long hold-off that the stimulus asks
	// for once. The sender keeps offering transactions through it, so the block backs up
	// and has to stall its own input.
	initial begin : result_receiver
		forever begin
			@(posedge clk);
			if (hold_request && !hold_served) begin
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_served = 1'b1;
			end
			out_stall <= ($urandom_range(99) < recv_idle_pct);
		end
	end

	// The watchdog ends a run that hangs, for example on a result that never arrives.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("[dram_row_buffer_latency_model_top] ERROR");
			$finish;
		end
	end

	// Offers one access transaction, after an optional random gap, and returns at the edge
	// at which the block takes it. Valid stays high afterwards so that back-to-back
	// transactions need no extra assignment; the next gap or the drain lowers it.
	task automatic offer_access(input logic [ADDR_W-1:0] addr, input logic wr,
			input logic known, input logic [LAT_W-1:0] lat, input outcome_t outc);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid     <= 1'b1;
		line_address <= addr;
		is_write     <= wr;
		step_known   <= known;
		step_lat     <= lat;
		step_outc    <= outc;
		@(posedge clk);
		while (in_stall) @(posedge clk);
	endtask

	// Stops offering and waits until every outstanding result has come back.
	task automatic wait_until_settled();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_timings.size() != 0) @(posedge clk);
	endtask

	// Registers only change while the block holds no work.
	task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] val);
		wait_until_settled();
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
	endtask

	initial begin : stimulus
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// The directed plan runs with random gaps on both sides.
		send_idle_pct = 11;
		recv_idle_pct = 50;
		foreach (directed_plan[i]) begin
			if (directed_plan[i].kind == STEP_CONFIG) begin
				write_register(directed_plan[i].index, directed_plan[i].data);
			end else begin
				offer_access(directed_plan[i].addr, directed_plan[i].wr,
					directed_plan[i].known_timing, directed_plan[i].lat,
					directed_plan[i].outc);
			end
		end

		// Random transactions in segments; each segment first writes registers and sets the idling.
		// The boolean registers also get random upper data bits, which must be ignored.
		for (int seg = 0; seg < SEGMENT_COUNT; seg++) begin
			case (seg)
				0: begin
					write_register(CFG_FIXED_MODE, {3'($urandom_range(7)), 1'b0});
					write_register(CFG_CLOSE_PAGE, {3'($urandom_range(7)), 1'b0});
					write_register(CFG_ROW_SHIFT, SHIFT_RESET);
				end
				1: write_register(CFG_ROW_SHIFT, 4'd0);
				2: begin
					write_register(CFG_CLOSE_PAGE, {3'($urandom_range(7)), 1'b1});
					write_register(CFG_ROW_SHIFT, 4'd10);
				end
				3: begin
					write_register(CFG_CLOSE_PAGE, {3'($urandom_range(7)), 1'b0});
					write_register(CFG_ROW_SHIFT, 4'd15);
				end
				4: write_register(CFG_FIXED_MODE, {3'($urandom_range(7)), 1'b1});
				default: begin
					write_register(CFG_FIXED_MODE, {3'($urandom_range(7)), 1'b0});
					write_register(CFG_ROW_SHIFT, 4'($urandom_range(15)));
				end
			endcase
			if (seg < 2) begin
				send_idle_pct = 11;
				recv_idle_pct = 50;
			end else if (seg < 4) begin
				send_idle_pct = 50;
				recv_idle_pct = 11;
			end else begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			// The long hold-off comes while the sender offers a transaction every cycle.
			if (seg == SEGMENT_COUNT - 1)
				hold_request <= 1'b1;
			repeat (SEGMENT_ITEMS) begin
				offer_access(pick_line_address(cfg_row_shift), 1'($urandom_range(1)), 1'b0,
					'0, OUTC_FIXED);
			end
		end

		// Let the last results drain, then keep the inputs quiet for SETTLE_CYCLES, so that any
		// stray result would still be caught.
		wait_until_settled();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("[dram_row_buffer_latency_model_top] OK");
		end else begin
			$display("[dram_row_buffer_latency_model_top] ERROR");
		end
		$finish;
	end

endmodule
